/* src/rhr_pkg.sv */
package rhr_pkg;

  // Hue circle and fixed-point constants.
  localparam int HUE_RANGE    = 80;
  localparam int HUE_HALF     = HUE_RANGE / 2;
  localparam int SECTOR_WIDTH = 43;
  localparam int INV_43_Q12   = 95;
  localparam int Q12_SHIFT    = 12;
  localparam int HUE_OFS_R    = 0;
  localparam int HUE_OFS_G    = 85;
  localparam int HUE_OFS_B    = 171;
  localparam logic [14:0] RGB_MASK = 15'h7FFF;

  // Which channel holds the maximum; ties favor red, then green.
  typedef enum logic [1:0] {
    MAX_R,
    MAX_G,
    MAX_B
  } max_sel_t;

  // Reciprocals 4096/delta in UQ1.12.
  localparam logic [12:0] RECIP_Q12 [32] = '{
    13'd0,    13'd4096, 13'd2048, 13'd1365, 13'd1024, 13'd819,  13'd683,  13'd585,
    13'd512,  13'd455,  13'd410,  13'd372,  13'd341,  13'd315,  13'd293,  13'd273,
    13'd256,  13'd241,  13'd228,  13'd216,  13'd205,  13'd195,  13'd186,  13'd178,
    13'd171,  13'd164,  13'd158,  13'd152,  13'd146,  13'd141,  13'd137,  13'd132
  };

  // Reciprocal of delta already scaled by the sector width (43 * 4096 / delta).
  function automatic logic [17:0] recip_scaled(input logic [4:0] delta);
    return 18'(SECTOR_WIDTH * RECIP_Q12[delta]);
  endfunction

  // Hue shift floor(seed * 80 / 255) - 40, kept modulo 256.
  // The divide by 255 uses (v + 1 + (v >> 8)) >> 8, exact for these values.
  function automatic logic [7:0] seed_shift(input logic [7:0] seed);
    logic [14:0] prod;
    logic [15:0] sum;
    prod = 15'(seed * HUE_RANGE);
    sum  = 16'(prod) + 16'd1 + 16'(prod >> 8);
    return sum[15:8] - 8'(HUE_HALF);
  endfunction

endpackage

/* src/rgb555_hue_rotate.sv */
// Hue rotation of one RGB555 palette color per clock. A request is taken at every
// rising edge where start is high; busy is always low, so a new color may follow in
// each cycle. The result appears on out_color_out with out_strobe high for one cycle,
// five cycles after the request edge, and must be captured then: there is no hold-off.
// The latency is set by a five-stage pipeline built around its two multipliers (the
// signed hue product and the x = f * delta product) and the sector divide by 43.
// Writing cfg_data with cfg_we high sets the hue seed; the resulting shift of -40..+40
// is computed at the write, so the seed should only change while no request is in flight.
// Entry 0, black, white and grey colors pass through unchanged; bit 15 is always kept.
module rgb555_hue_rotate (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_entry_index,
  input  logic [15:0] in_color_in,
  output logic        out_strobe,
  output logic [15:0] out_color_out,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);

  // Configuration: hue shift derived from the seed at write time.
  logic [7:0] hue_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_shift_r <= rhr_pkg::seed_shift(8'd0);
    end else if (cfg_we) begin
      hue_shift_r <= rhr_pkg::seed_shift(cfg_data);
    end
  end

  // The pipeline never stalls.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: split channels, find max, min, delta and the hue difference.
  logic [4:0]           c_r, c_g, c_b, c_mx, c_mn, c_delta;
  logic                 c_pass;
  rhr_pkg::max_sel_t    c_sel;
  logic signed [5:0]    c_diff;
  logic [7:0]           c_ofs;

  always_comb begin
    c_r = in_color_in[4:0];
    c_g = in_color_in[9:5];
    c_b = in_color_in[14:10];
    c_mx = c_r;
    c_mn = c_r;
    if (c_g > c_mx) c_mx = c_g;
    if (c_g < c_mn) c_mn = c_g;
    if (c_b > c_mx) c_mx = c_b;
    if (c_b < c_mn) c_mn = c_b;
    c_delta = c_mx - c_mn;
    c_pass = (in_entry_index == 4'd0) || (in_color_in == 16'd0) ||
             (in_color_in[14:0] == rhr_pkg::RGB_MASK) || (c_delta == 5'd0);
    if (c_mx == c_r) begin
      c_sel = rhr_pkg::MAX_R;
    end else if (c_mx == c_g) begin
      c_sel = rhr_pkg::MAX_G;
    end else begin
      c_sel = rhr_pkg::MAX_B;
    end
    case (c_sel)
      rhr_pkg::MAX_R: begin
        c_diff = signed'({1'b0, c_g}) - signed'({1'b0, c_b});
        c_ofs  = 8'(rhr_pkg::HUE_OFS_R) + hue_shift_r;
      end
      rhr_pkg::MAX_G: begin
        c_diff = signed'({1'b0, c_b}) - signed'({1'b0, c_r});
        c_ofs  = 8'(rhr_pkg::HUE_OFS_G) + hue_shift_r;
      end
      default: begin
        c_diff = signed'({1'b0, c_r}) - signed'({1'b0, c_g});
        c_ofs  = 8'(rhr_pkg::HUE_OFS_B) + hue_shift_r;
      end
    endcase
  end

  logic              s1_vld_r;
  logic              s1_pass_r;
  logic [15:0]       s1_color_r;
  logic [4:0]        s1_mn_r, s1_delta_r;
  logic [7:0]        s1_ofs_r;
  logic signed [5:0] s1_diff_r;
  logic [17:0]       s1_recip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_pass_r  <= c_pass;
    s1_color_r <= in_color_in;
    s1_mn_r    <= c_mn;
    s1_delta_r <= c_delta;
    s1_ofs_r   <= c_ofs;
    s1_diff_r  <= c_diff;
    s1_recip_r <= rhr_pkg::recip_scaled(c_delta);
  end

  // Stage 2: signed product 43 * recip * diff.
  logic signed [18:0] s1_recip_s;
  logic signed [24:0] c_prod;

  assign s1_recip_s = signed'({1'b0, s1_recip_r});
  assign c_prod     = s1_recip_s * s1_diff_r;

  logic               s2_vld_r;
  logic               s2_pass_r;
  logic [15:0]        s2_color_r;
  logic [4:0]         s2_mn_r, s2_delta_r;
  logic [7:0]         s2_ofs_r;
  logic signed [24:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_pass_r  <= s1_pass_r;
    s2_color_r <= s1_color_r;
    s2_mn_r    <= s1_mn_r;
    s2_delta_r <= s1_delta_r;
    s2_ofs_r   <= s1_ofs_r;
    s2_prod_r  <= c_prod;
  end

  // Stage 3: floor divide by 4096, add offset and shift, find the sector.
  logic signed [24:0] c_floor;
  logic [7:0]         c_hn;
  logic [14:0]        c_sec_prod;
  logic [2:0]         c_sector;

  assign c_floor    = s2_prod_r >>> rhr_pkg::Q12_SHIFT;
  assign c_hn       = c_floor[7:0] + s2_ofs_r;
  assign c_sec_prod = 15'(c_hn * rhr_pkg::INV_43_Q12);
  assign c_sector   = c_sec_prod[14:12];

  logic        s3_vld_r;
  logic        s3_pass_r;
  logic [15:0] s3_color_r;
  logic [4:0]  s3_mn_r, s3_delta_r;
  logic [7:0]  s3_hn_r;
  logic [2:0]  s3_sector_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_pass_r   <= s2_pass_r;
    s3_color_r  <= s2_color_r;
    s3_mn_r     <= s2_mn_r;
    s3_delta_r  <= s2_delta_r;
    s3_hn_r     <= c_hn;
    s3_sector_r <= c_sector;
  end

  // Stage 4: position within the sector, clamped, then scaled by 95.
  logic [7:0]  c_f_raw;
  logic [5:0]  c_f;
  logic [11:0] c_fs;

  assign c_f_raw = s3_hn_r - 8'(rhr_pkg::SECTOR_WIDTH * s3_sector_r);
  assign c_f     = (c_f_raw > 8'(rhr_pkg::SECTOR_WIDTH)) ? 6'(rhr_pkg::SECTOR_WIDTH)
                                                         : c_f_raw[5:0];
  assign c_fs    = 12'(c_f * rhr_pkg::INV_43_Q12);

  logic        s4_vld_r;
  logic        s4_pass_r;
  logic [15:0] s4_color_r;
  logic [4:0]  s4_mn_r, s4_delta_r;
  logic [2:0]  s4_sector_r;
  logic [11:0] s4_fs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_pass_r   <= s3_pass_r;
    s4_color_r  <= s3_color_r;
    s4_mn_r     <= s3_mn_r;
    s4_delta_r  <= s3_delta_r;
    s4_sector_r <= s3_sector_r;
    s4_fs_r     <= c_fs;
  end

  // Stage 5: x = f * delta / 43, six-sector rebuild around the minimum.
  logic [16:0] c_x_prod;
  logic [4:0]  c_x, c_inv, c_r1, c_g1, c_b1;
  logic [15:0] c_out;

  always_comb begin
    c_x_prod = 17'(s4_fs_r * s4_delta_r);
    c_x      = c_x_prod[16:12];
    if (c_x > s4_delta_r) c_x = s4_delta_r;
    c_inv = s4_delta_r - c_x;
    case (s4_sector_r)
      3'd0: begin c_r1 = s4_delta_r; c_g1 = c_x;        c_b1 = 5'd0;       end
      3'd1: begin c_r1 = c_inv;      c_g1 = s4_delta_r; c_b1 = 5'd0;       end
      3'd2: begin c_r1 = 5'd0;       c_g1 = s4_delta_r; c_b1 = c_x;        end
      3'd3: begin c_r1 = 5'd0;       c_g1 = c_inv;      c_b1 = s4_delta_r; end
      3'd4: begin c_r1 = c_x;        c_g1 = 5'd0;       c_b1 = s4_delta_r; end
      default: begin c_r1 = s4_delta_r; c_g1 = 5'd0;    c_b1 = c_inv;      end
    endcase
    if (s4_pass_r) begin
      c_out = s4_color_r;
    end else begin
      c_out = {s4_color_r[15], c_b1 + s4_mn_r, c_g1 + s4_mn_r, c_r1 + s4_mn_r};
    end
  end

  // Output register.
  logic        out_strobe_r;
  logic [15:0] out_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_color_r <= c_out;
  end

  assign out_strobe    = out_strobe_r;
  assign out_color_out = out_color_r;

  // Every request yields exactly one result, through registers s1 to s4 and the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##4 out_strobe)
    else $error("request did not produce a result after five cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 5))
    else $error("result strobe without a matching request");

  // Entry zero passes through untouched.
  a_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_entry_index, 5) == 4'd0) |->
      out_color_out == $past(in_color_in, 5))
    else $error("entry zero was modified");

  // The flag bit always survives.
  a_flag_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_color_out[15] == $past(in_color_in[15], 5))
    else $error("bit 15 was not preserved");

  // The sector from the divide by 43 never exceeds five.
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> s3_sector_r <= 3'd5)
    else $error("hue sector out of range");

endmodule
